### hw/rtl/rprt_pkg.sv
// shared types and constants of the received packet range tracker
`timescale 1ns / 1ps

package rprt_pkg;

    localparam int PN_W = 62;

    localparam logic [1:0] MODE_RECV    = 2'd0;
    localparam logic [1:0] MODE_ACK     = 2'd1;
    localparam logic [1:0] MODE_INSTALL = 2'd2;
    localparam logic [1:0] MODE_DISCARD = 2'd3;

    localparam logic [1:0] KEY_NONE      = 2'd0;
    localparam logic [1:0] KEY_INSTALLED = 2'd1;
    localparam logic [1:0] KEY_DISCARDED = 2'd2;

    typedef struct packed {
        logic [1:0]      mode;
        logic [PN_W-1:0] pn;
        logic            dup;
        logic            drop;
        logic            touch_up;
        logic            touch_low;
    } work_t;

endpackage

### hw/rtl/rprt_queue.sv
// two-entry valid/ready queue between the classifier and the range updater
`timescale 1ns / 1ps

module rprt_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   fill_reg;

    logic push;
    logic pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

### hw/rtl/rprt_front.sv
// input register and classifier: compares one item against all stored ranges
`timescale 1ns / 1ps

module rprt_front #(
    parameter int MAX_RANGES = 32,
    parameter int CW = $clog2(MAX_RANGES + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_mode,
    input  logic [rprt_pkg::PN_W-1:0] s_packet_number,
    input  logic [rprt_pkg::PN_W-1:0] range_start [MAX_RANGES],
    input  logic [rprt_pkg::PN_W-1:0] range_end [MAX_RANGES],
    input  logic [CW-1:0]            range_cnt,
    input  logic                     item_done,
    output logic                     q_valid,
    input  logic                     q_ready,
    output rprt_pkg::work_t          q_work,
    output logic [MAX_RANGES-1:0]    q_above
);

    logic                      in_valid_reg;
    logic [1:0]                in_mode_reg;
    logic [rprt_pkg::PN_W-1:0] in_pn_reg;
    logic                      pending_reg;

    logic                      full;
    logic                      dup;
    logic                      drop;
    logic                      up_hit;
    logic                      low_hit;
    logic                      recv;
    logic [rprt_pkg::PN_W:0]   pn_plus;
    logic [rprt_pkg::PN_W-1:0] pn_minus;

    assign s_ready  = !in_valid_reg;
    assign full     = (range_cnt == CW'(MAX_RANGES));
    assign recv     = (in_mode_reg == rprt_pkg::MODE_RECV);
    assign pn_plus  = {1'b0, in_pn_reg} + {{rprt_pkg::PN_W{1'b0}}, 1'b1};
    assign pn_minus = in_pn_reg - {{(rprt_pkg::PN_W-1){1'b0}}, 1'b1};

    always_comb begin
        logic vld;
        logic vld_eff;
        dup     = 1'b0;
        up_hit  = 1'b0;
        low_hit = 1'b0;
        q_above = '0;
        for (int j = 0; j < MAX_RANGES; j++) begin
            vld     = (CW'(j) < range_cnt);
            // the lowest range is overwritten when the table is full
            vld_eff = vld && !(full && (j == MAX_RANGES - 1));
            if (vld && in_pn_reg >= range_start[j] && in_pn_reg <= range_end[j]) begin
                dup = 1'b1;
            end
            q_above[j] = vld && (range_start[j] > in_pn_reg);
            if (vld && {1'b0, range_start[j]} == pn_plus) begin
                up_hit = 1'b1;
            end
            if (vld_eff && in_pn_reg != '0 && range_end[j] == pn_minus) begin
                low_hit = 1'b1;
            end
        end
        drop = full && !dup && (in_pn_reg <= range_start[MAX_RANGES-1]);
    end

    always_comb begin
        q_work.mode      = in_mode_reg;
        q_work.pn        = in_pn_reg;
        q_work.dup       = recv && dup;
        q_work.drop      = recv && drop;
        q_work.touch_up  = recv && !dup && !drop && up_hit;
        q_work.touch_low = recv && !dup && !drop && low_hit;
    end

    // classify only against settled state: wait until the previous item is done
    assign q_valid = in_valid_reg && !pending_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg <= s_mode;
            in_pn_reg   <= s_packet_number;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            pending_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (q_valid && q_ready) begin
                in_valid_reg <= 1'b0;
            end
            if (q_valid && q_ready) begin
                pending_reg <= 1'b1;
            end else if (item_done) begin
                pending_reg <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/rprt_back.sv
// range updater: insert, merge, tracked maxima, key state and result register
`timescale 1ns / 1ps

module rprt_back #(
    parameter int MAX_RANGES = 32,
    parameter int CW = $clog2(MAX_RANGES + 1)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  rprt_pkg::work_t           q_work,
    input  logic [MAX_RANGES-1:0]     q_above,
    output logic [rprt_pkg::PN_W-1:0] range_start [MAX_RANGES],
    output logic [rprt_pkg::PN_W-1:0] range_end [MAX_RANGES],
    output logic [CW-1:0]             range_cnt,
    output logic                      item_done,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_is_duplicate,
    output logic                      m_was_dropped,
    output logic [5:0]                m_range_count,
    output logic [rprt_pkg::PN_W-1:0] m_top_range_start,
    output logic [rprt_pkg::PN_W-1:0] m_top_range_end,
    output logic [rprt_pkg::PN_W-1:0] m_largest_received,
    output logic                      m_largest_received_valid,
    output logic [rprt_pkg::PN_W-1:0] m_largest_peer_acked,
    output logic                      m_largest_peer_acked_valid,
    output logic [1:0]                m_key_status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INS  = 2'd1;
    localparam logic [1:0] ST_MRG  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [rprt_pkg::PN_W-1:0] s_reg [MAX_RANGES];
    logic [rprt_pkg::PN_W-1:0] s_next [MAX_RANGES];
    logic [rprt_pkg::PN_W-1:0] e_reg [MAX_RANGES];
    logic [rprt_pkg::PN_W-1:0] e_next [MAX_RANGES];
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [rprt_pkg::PN_W-1:0] hr_reg, hr_next;
    logic                      hr_seen_reg, hr_seen_next;
    logic [rprt_pkg::PN_W-1:0] pa_reg, pa_next;
    logic                      pa_seen_reg, pa_seen_next;
    logic [1:0]                key_reg, key_next;

    rprt_pkg::work_t           work_reg;
    logic [MAX_RANGES-1:0]     above_reg;
    logic [MAX_RANGES-1:0]     at_pos;
    logic                      ins;
    logic                      out_free;
    logic [CW+5:0]             cnt_wide;

    assign range_start = s_reg;
    assign range_end   = e_reg;
    assign range_cnt   = cnt_reg;
    assign q_ready     = (state_reg == ST_IDLE);
    assign ins         = (work_reg.mode == rprt_pkg::MODE_RECV) && !work_reg.dup
                         && !work_reg.drop;
    assign out_free    = !m_valid || m_ready;
    assign item_done   = (state_reg == ST_DONE) && out_free;
    assign cnt_wide    = {6'd0, cnt_reg};

    // one-hot slot of the new range: first entry whose start is not above it
    always_comb begin
        for (int j = 0; j < MAX_RANGES; j++) begin
            at_pos[j] = !above_reg[j] && ((j == 0) || above_reg[(j == 0) ? 0 : j - 1]);
        end
    end

    always_comb begin
        int  i1;
        int  i2;
        int  ip;
        logic up_slot;
        i1           = 0;
        i2           = 0;
        ip           = 0;
        up_slot      = 1'b0;
        state_next   = state_reg;
        s_next       = s_reg;
        e_next       = e_reg;
        cnt_next     = cnt_reg;
        hr_next      = hr_reg;
        hr_seen_next = hr_seen_reg;
        pa_next      = pa_reg;
        pa_seen_next = pa_seen_reg;
        key_next     = key_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_INS;
                end
            end
            ST_INS: begin
                state_next = ST_MRG;
                unique case (work_reg.mode)
                    rprt_pkg::MODE_RECV: begin
                        if (!hr_seen_reg || work_reg.pn > hr_reg) begin
                            hr_next      = work_reg.pn;
                            hr_seen_next = 1'b1;
                        end
                        if (ins) begin
                            for (int j = 0; j < MAX_RANGES; j++) begin
                                ip = (j == 0) ? 0 : j - 1;
                                if (at_pos[j]) begin
                                    s_next[j] = work_reg.pn;
                                    e_next[j] = work_reg.pn;
                                end else if (!above_reg[j]) begin
                                    s_next[j] = s_reg[ip];
                                    e_next[j] = e_reg[ip];
                                end
                            end
                            if (cnt_reg != CW'(MAX_RANGES)) begin
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                    end
                    rprt_pkg::MODE_ACK: begin
                        if (!pa_seen_reg || work_reg.pn > pa_reg) begin
                            pa_next      = work_reg.pn;
                            pa_seen_next = 1'b1;
                        end
                    end
                    rprt_pkg::MODE_INSTALL: begin
                        key_next = rprt_pkg::KEY_INSTALLED;
                    end
                    rprt_pkg::MODE_DISCARD: begin
                        key_next     = rprt_pkg::KEY_DISCARDED;
                        cnt_next     = '0;
                        hr_next      = '0;
                        hr_seen_next = 1'b0;
                    end
                    default: ;
                endcase
            end
            ST_MRG: begin
                state_next = ST_DONE;
                if (ins && (work_reg.touch_up || work_reg.touch_low)) begin
                    for (int j = 0; j < MAX_RANGES; j++) begin
                        i1      = (j + 1 < MAX_RANGES) ? j + 1 : MAX_RANGES - 1;
                        i2      = (j + 2 < MAX_RANGES) ? j + 2 : MAX_RANGES - 1;
                        up_slot = (j + 1 < MAX_RANGES) && at_pos[i1];
                        if (work_reg.touch_up && work_reg.touch_low) begin
                            // the new number bridges its two neighbors
                            if (up_slot) begin
                                s_next[j] = s_reg[i2];
                            end else if (!above_reg[j]) begin
                                s_next[j] = s_reg[i2];
                                e_next[j] = e_reg[i2];
                            end
                        end else if (work_reg.touch_up) begin
                            if (up_slot) begin
                                s_next[j] = work_reg.pn;
                            end else if (!above_reg[j]) begin
                                s_next[j] = s_reg[i1];
                                e_next[j] = e_reg[i1];
                            end
                        end else begin
                            if (at_pos[j]) begin
                                s_next[j] = s_reg[i1];
                            end else if (!above_reg[j]) begin
                                s_next[j] = s_reg[i1];
                                e_next[j] = e_reg[i1];
                            end
                        end
                    end
                    if (work_reg.touch_up && work_reg.touch_low) begin
                        cnt_next = cnt_reg - CW'(2);
                    end else begin
                        cnt_next = cnt_reg - CW'(1);
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        s_reg <= s_next;
        e_reg <= e_next;
        if (q_valid && q_ready) begin
            work_reg  <= q_work;
            above_reg <= q_above;
        end
        if (item_done) begin
            m_is_duplicate           <= work_reg.dup;
            m_was_dropped            <= work_reg.drop;
            m_range_count            <= cnt_wide[5:0];
            m_top_range_start        <= (cnt_reg != '0) ? s_reg[0] : '0;
            m_top_range_end          <= (cnt_reg != '0) ? e_reg[0] : '0;
            m_largest_received       <= hr_seen_reg ? hr_reg : '0;
            m_largest_received_valid <= hr_seen_reg;
            m_largest_peer_acked     <= pa_seen_reg ? pa_reg : '0;
            m_largest_peer_acked_valid <= pa_seen_reg;
            m_key_status             <= key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            hr_reg      <= '0;
            hr_seen_reg <= 1'b0;
            pa_reg      <= '0;
            pa_seen_reg <= 1'b0;
            key_reg     <= rprt_pkg::KEY_NONE;
            m_valid     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            hr_reg      <= hr_next;
            hr_seen_reg <= hr_seen_next;
            pa_reg      <= pa_next;
            pa_seen_reg <= pa_seen_next;
            key_reg     <= key_next;
            if (item_done) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/received_packet_range_tracker.sv
// Received packet range tracker: ranges of received packet numbers of one space.
//
// Input channel s_valid/s_ready carries one item: s_mode (received, peer ack,
// key installed, key discarded) and s_packet_number. Every item gives exactly
// one result on m_valid/m_ready with duplicate/drop flags, the stored range
// count, the highest stored range, the largest received and peer-acked numbers
// and the key status.
// The front registers the item and compares it in parallel against all stored
// ranges; the back inserts the new range in its insert state and merges it
// with touching neighbors in the merge state after it. A two-entry queue sits
// between them. A new item is taken into the input register while the
// previous one is still in work, and classified once the back has finished
// it, so items are classified one at a time, since the classify, insert and
// merge steps work on shared range state.
// Reset (aresetn low, synchronous) empties the table and clears the maxima
// and the key status. When the receiver stalls the result stays in the output
// register; one more item is held at the input and then s_ready drops.
`timescale 1ns / 1ps

module received_packet_range_tracker #(
    parameter int MAX_RANGES = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_mode,
    input  logic [61:0]  s_packet_number,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_is_duplicate,
    output logic         m_was_dropped,
    output logic [5:0]   m_range_count,
    output logic [61:0]  m_top_range_start,
    output logic [61:0]  m_top_range_end,
    output logic [61:0]  m_largest_received,
    output logic         m_largest_received_valid,
    output logic [61:0]  m_largest_peer_acked,
    output logic         m_largest_peer_acked_valid,
    output logic [1:0]   m_key_status
);

    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int QW = $bits(rprt_pkg::work_t) + MAX_RANGES;

    logic [rprt_pkg::PN_W-1:0] range_start [MAX_RANGES];
    logic [rprt_pkg::PN_W-1:0] range_end [MAX_RANGES];
    logic [CW-1:0]             range_cnt;
    logic                      item_done;

    logic                  fq_valid, fq_ready;
    rprt_pkg::work_t       fq_work;
    logic [MAX_RANGES-1:0] fq_above;
    logic                  bq_valid, bq_ready;
    logic [QW-1:0]         bq_data;
    rprt_pkg::work_t       bq_work;
    logic [MAX_RANGES-1:0] bq_above;

    assign bq_work  = bq_data[QW-1:MAX_RANGES];
    assign bq_above = bq_data[MAX_RANGES-1:0];

    rprt_front #(.MAX_RANGES(MAX_RANGES), .CW(CW)) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_packet_number (s_packet_number),
        .range_start     (range_start),
        .range_end       (range_end),
        .range_cnt       (range_cnt),
        .item_done       (item_done),
        .q_valid         (fq_valid),
        .q_ready         (fq_ready),
        .q_work          (fq_work),
        .q_above         (fq_above)
    );

    rprt_queue #(.W(QW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({fq_work, fq_above}),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    rprt_back #(.MAX_RANGES(MAX_RANGES), .CW(CW)) u_back (
        .aclk                       (aclk),
        .aresetn                    (aresetn),
        .q_valid                    (bq_valid),
        .q_ready                    (bq_ready),
        .q_work                     (bq_work),
        .q_above                    (bq_above),
        .range_start                (range_start),
        .range_end                  (range_end),
        .range_cnt                  (range_cnt),
        .item_done                  (item_done),
        .m_valid                    (m_valid),
        .m_ready                    (m_ready),
        .m_is_duplicate             (m_is_duplicate),
        .m_was_dropped              (m_was_dropped),
        .m_range_count              (m_range_count),
        .m_top_range_start          (m_top_range_start),
        .m_top_range_end            (m_top_range_end),
        .m_largest_received         (m_largest_received),
        .m_largest_received_valid   (m_largest_received_valid),
        .m_largest_peer_acked       (m_largest_peer_acked),
        .m_largest_peer_acked_valid (m_largest_peer_acked_valid),
        .m_key_status               (m_key_status)
    );

endmodule

### verif/received_packet_range_tracker_chk.sv
// checker: predicts tracker results and compares them with the result channel
`timescale 1ns / 1ps

module received_packet_range_tracker_chk #(
    parameter int MAX_RANGES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [61:0] s_packet_number,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_is_duplicate,
    input  logic        m_was_dropped,
    input  logic [5:0]  m_range_count,
    input  logic [61:0] m_top_range_start,
    input  logic [61:0] m_top_range_end,
    input  logic [61:0] m_largest_received,
    input  logic        m_largest_received_valid,
    input  logic [61:0] m_largest_peer_acked,
    input  logic        m_largest_peer_acked_valid,
    input  logic [1:0]  m_key_status,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic        dup;
        logic        drop;
        logic [5:0]  cnt;
        logic [61:0] top_s;
        logic [61:0] top_e;
        logic [61:0] lrx;
        logic        lrx_v;
        logic [61:0] lack;
        logic        lack_v;
        logic [1:0]  key;
    } status_t;

    logic [61:0] rng_lo [MAX_RANGES];
    logic [61:0] rng_hi [MAX_RANGES];
    int          n_rng;
    logic [61:0] max_rx;
    logic        max_rx_v;
    logic [61:0] max_ack;
    logic        max_ack_v;
    logic [1:0]  key_st;
    status_t     status_q[$];

    assign pending_count = status_q.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // fold neighbors that touch or overlap, walking from the top
    task automatic fold_ranges();
        int i;
        i = 0;
        while (i + 1 < n_rng) begin
            if ({2'b0, rng_hi[i+1]} + 64'd1 < {2'b0, rng_lo[i]}) begin
                i++;
            end else begin
                if (rng_lo[i+1] < rng_lo[i]) rng_lo[i] = rng_lo[i+1];
                if (rng_hi[i+1] > rng_hi[i]) rng_hi[i] = rng_hi[i+1];
                for (int t = i + 1; t + 1 < n_rng; t++) begin
                    rng_lo[t] = rng_lo[t+1];
                    rng_hi[t] = rng_hi[t+1];
                end
                n_rng--;
            end
        end
    endtask

    task automatic track_item(input logic [1:0] mode, input logic [61:0] pn);
        status_t r;
        int at;
        logic [61:0] tmp;
        r = '0;
        case (mode)
            rprt_pkg::MODE_RECV: begin
                if (!max_rx_v || pn > max_rx) begin
                    max_rx = pn;
                    max_rx_v = 1'b1;
                end
                for (int i = 0; i < n_rng; i++)
                    if (pn >= rng_lo[i] && pn <= rng_hi[i]) r.dup = 1'b1;
                if (!r.dup) begin
                    if (n_rng < MAX_RANGES) begin
                        at = n_rng;
                        n_rng++;
                    end else begin
                        at = MAX_RANGES - 1;
                        if (pn <= rng_lo[at]) r.drop = 1'b1;
                    end
                    if (!r.drop) begin
                        rng_lo[at] = pn;
                        rng_hi[at] = pn;
                        while (at > 0 && rng_lo[at] > rng_lo[at-1]) begin
                            tmp = rng_lo[at]; rng_lo[at] = rng_lo[at-1]; rng_lo[at-1] = tmp;
                            tmp = rng_hi[at]; rng_hi[at] = rng_hi[at-1]; rng_hi[at-1] = tmp;
                            at--;
                        end
                        fold_ranges();
                    end
                end
            end
            rprt_pkg::MODE_ACK: begin
                if (!max_ack_v || pn > max_ack) begin
                    max_ack = pn;
                    max_ack_v = 1'b1;
                end
            end
            rprt_pkg::MODE_INSTALL: key_st = rprt_pkg::KEY_INSTALLED;
            default: begin
                key_st = rprt_pkg::KEY_DISCARDED;
                n_rng = 0;
                max_rx = '0;
                max_rx_v = 1'b0;
            end
        endcase
        r.cnt = n_rng[5:0];
        r.top_s = n_rng > 0 ? rng_lo[0] : '0;
        r.top_e = n_rng > 0 ? rng_hi[0] : '0;
        r.lrx = max_rx_v ? max_rx : '0;
        r.lrx_v = max_rx_v;
        r.lack = max_ack_v ? max_ack : '0;
        r.lack_v = max_ack_v;
        r.key = key_st;
        status_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        status_t w;
        if (!aresetn) begin
            fail_count = 0;
            n_rng = 0;
            max_rx = '0;
            max_rx_v = 1'b0;
            max_ack = '0;
            max_ack_v = 1'b0;
            key_st = rprt_pkg::KEY_NONE;
            status_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (status_q.size() == 0) begin
                    $display("unexpected result item at %0t", $realtime);
                    fail_count++;
                end else begin
                    w = status_q.pop_front();
                    if (m_is_duplicate !== w.dup)
                        report("is_duplicate", 64'(m_is_duplicate), 64'(w.dup));
                    if (m_was_dropped !== w.drop)
                        report("was_dropped", 64'(m_was_dropped), 64'(w.drop));
                    if (m_range_count !== w.cnt)
                        report("range_count", 64'(m_range_count), 64'(w.cnt));
                    if (m_top_range_start !== w.top_s)
                        report("top_range_start", 64'(m_top_range_start), 64'(w.top_s));
                    if (m_top_range_end !== w.top_e)
                        report("top_range_end", 64'(m_top_range_end), 64'(w.top_e));
                    if (m_largest_received !== w.lrx)
                        report("largest_received", 64'(m_largest_received), 64'(w.lrx));
                    if (m_largest_received_valid !== w.lrx_v)
                        report("largest_received_valid", 64'(m_largest_received_valid),
                               64'(w.lrx_v));
                    if (m_largest_peer_acked !== w.lack)
                        report("largest_peer_acked", 64'(m_largest_peer_acked), 64'(w.lack));
                    if (m_largest_peer_acked_valid !== w.lack_v)
                        report("largest_peer_acked_valid", 64'(m_largest_peer_acked_valid),
                               64'(w.lack_v));
                    if (m_key_status !== w.key)
                        report("key_status", 64'(m_key_status), 64'(w.key));
                end
            end
            if (s_valid && s_ready) track_item(s_mode, s_packet_number);
        end
    end

endmodule

### verif/received_packet_range_tracker_tb.sv
// testbench top: stimulus, handshake idling and the verdict for the range tracker
`timescale 1ns / 1ps

module received_packet_range_tracker_tb;

    localparam logic [61:0] PN_MAX = {62{1'b1}};

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [61:0] s_packet_number;
    logic        m_valid;
    logic        m_ready;
    logic        m_is_duplicate;
    logic        m_was_dropped;
    logic [5:0]  m_range_count;
    logic [61:0] m_top_range_start;
    logic [61:0] m_top_range_end;
    logic [61:0] m_largest_received;
    logic        m_largest_received_valid;
    logic [61:0] m_largest_peer_acked;
    logic        m_largest_peer_acked_valid;
    logic [1:0]  m_key_status;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic [61:0] pn_base;

    received_packet_range_tracker u_top (.*);

    received_packet_range_tracker_chk u_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    // receiver stalls at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // valid stays high between back-to-back items and drops only while idling
    task automatic send_item(input logic [1:0] mode, input logic [61:0] pn);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_packet_number <= pn;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count > 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
    endtask

    // random received number: mostly clustered near a moving base, so
    // ranges build up, touch, merge and fill the table
    function automatic logic [61:0] near_pn();
        logic [61:0] v;
        case ($urandom_range(9))
            0: v = 62'({$urandom, $urandom});
            1: v = 62'($urandom_range(200));
            default: v = pn_base + 62'($urandom_range(90));
        endcase
        return v;
    endfunction

    task automatic random_phase(input int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 80) begin
                send_item(rprt_pkg::MODE_RECV, near_pn());
            end else if (r < 92) begin
                send_item(rprt_pkg::MODE_ACK,
                          $urandom_range(1) ? near_pn() : 62'({$urandom, $urandom}));
            end else if (r < 96) begin
                send_item(rprt_pkg::MODE_INSTALL, 62'({$urandom, $urandom}));
            end else begin
                send_item(rprt_pkg::MODE_DISCARD, 62'({$urandom, $urandom}));
                pn_base = 62'({$urandom, $urandom} >> $urandom_range(40));
            end
            if ($urandom_range(199) == 0) pn_base = pn_base + 62'd150;
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = rprt_pkg::MODE_RECV;
        s_packet_number = '0;
        m_ready = 1'b0;
        send_idle_pct = 9;
        recv_idle_pct = 73;
        pn_base = 62'd1000;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, every mode, duplicates, merges, key cycle
        send_item(rprt_pkg::MODE_ACK, 62'd5);
        send_item(rprt_pkg::MODE_ACK, 62'd3);
        send_item(rprt_pkg::MODE_RECV, PN_MAX);
        send_item(rprt_pkg::MODE_RECV, PN_MAX);
        send_item(rprt_pkg::MODE_RECV, 62'd0);
        send_item(rprt_pkg::MODE_RECV, 62'd2);
        send_item(rprt_pkg::MODE_RECV, 62'd1);
        send_item(rprt_pkg::MODE_RECV, PN_MAX - 62'd1);
        send_item(rprt_pkg::MODE_ACK, PN_MAX);
        send_item(rprt_pkg::MODE_INSTALL, PN_MAX);
        send_item(rprt_pkg::MODE_DISCARD, 62'd0);
        send_item(rprt_pkg::MODE_RECV, 62'd7);
        send_item(rprt_pkg::MODE_INSTALL, 62'd0);
        send_item(rprt_pkg::MODE_ACK, 62'd0);
        send_item(rprt_pkg::MODE_DISCARD, PN_MAX);
        drain();

        // full table: 34 isolated numbers, then lower (dropped) and higher
        for (int k = 0; k < 34; k++) send_item(rprt_pkg::MODE_RECV, 62'd100 + 62'(k * 3));
        send_item(rprt_pkg::MODE_RECV, 62'd50);
        send_item(rprt_pkg::MODE_RECV, 62'd101);
        send_item(rprt_pkg::MODE_RECV, 62'd500);
        send_item(rprt_pkg::MODE_DISCARD, 62'd0);

        random_phase(500);
        drain();
        send_idle_pct = 73;
        recv_idle_pct = 9;
        random_phase(500);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(500);
        drain();

        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
